/* rtl/tmp_pkg.sv */
// Package for the trapezoid motion profile generator.
// Holds operation codes, state encodings, the divider request and response structs and caps.
// No dependencies.
`timescale 1ns / 1ps
package tmp_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_ABORT = 2'd3
  } op_t;

  typedef enum logic {
    REG_MOVE_DISTANCE   = 1'b0,
    REG_CRUISE_VELOCITY = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SP,
    ST_SQ,
    ST_SL,
    ST_SC,
    ST_S3,
    ST_S23,
    ST_K2,
    ST_TQ,
    ST_TL,
    ST_FIN,
    ST_OUT
  } ctl_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] d;
    logic [63:0] cap;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } md_rsp_t;

  localparam logic [63:0] CAP_P    = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] CAP_COEF = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] CAP_TERM = 64'h1000_0000_0000_0000;
  localparam logic [63:0] CAP_ALL  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic signed [65:0] POS_MAX = 66'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [65:0] POS_MIN = -66'sh0_8000_0000_0000;

endpackage

/* rtl/tmp_muldiv.sv */
// Bit-serial unit computing floor(a*b/d), saturated at a cap.
// Shift-add multiply one bit a cycle, then restoring division one bit a cycle.
// Depends on tmp_pkg.
`timescale 1ns / 1ps
module tmp_muldiv
  import tmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  md_req_t req,
  output md_rsp_t rsp
);

  md_state_t    st_r, st_nxt;
  logic [6:0]   cnt_r;
  logic [63:0]  a_r, b_r, d_r, cap_r, rem_r, q_r;
  logic [127:0] prod_r;
  logic         done_r;

  logic [64:0]  mul_sum;
  logic [127:0] mul_nxt;
  logic [64:0]  rr;
  logic         qbit;
  logic [63:0]  rem_nxt;
  logic [127:0] div_nxt;

  always_comb begin
    mul_sum = {1'b0, prod_r[127:64]} + (b_r[0] ? {1'b0, a_r} : 65'd0);
    mul_nxt = {mul_sum, prod_r[63:1]};
    rr      = {rem_r, prod_r[127]};
    qbit    = (rr >= {1'b0, d_r});
    rem_nxt = qbit ? 64'(rr - {1'b0, d_r}) : rr[63:0];
    div_nxt = {prod_r[126:0], qbit};
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      MD_IDLE: if (req.start) st_nxt = MD_MUL;
      MD_MUL:  if (cnt_r == 7'd63) st_nxt = MD_DIV;
      MD_DIV:  if (cnt_r == 7'd127) st_nxt = MD_IDLE;
      default: st_nxt = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MD_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == MD_DIV) && (cnt_r == 7'd127);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      MD_IDLE: begin
        if (req.start) begin
          a_r    <= req.a;
          b_r    <= req.b;
          d_r    <= req.d;
          cap_r  <= req.cap;
          prod_r <= '0;
          rem_r  <= '0;
          cnt_r  <= '0;
        end
      end
      MD_MUL: begin
        prod_r <= mul_nxt;
        b_r    <= b_r >> 1;
        cnt_r  <= (cnt_r == 7'd63) ? 7'd0 : cnt_r + 7'd1;
      end
      MD_DIV: begin
        prod_r <= div_nxt;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r + 7'd1;
        if (cnt_r == 7'd127) begin
          // A zero divisor or a quotient above the cap returns the cap.
          q_r <= (d_r == 64'd0 || div_nxt[127:64] != 64'd0 || div_nxt[63:0] > cap_r)
                 ? cap_r : div_nxt[63:0];
        end
      end
      default: ;
    endcase
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

/* rtl/trapezoid_motion_profile.sv */
// Top level of the trapezoid motion profile generator: control sequencer and state.
// Depends on tmp_pkg and tmp_muldiv.
//
// Channel  Direction  Handshake               Content
// in_      slave      in_tvalid/in_tready     tdata position_value, tuser operation
// out_     master     out_tvalid/out_tready   tdata commanded_position, moving
// cfg_     slave      cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One request at a time. Each pass through the serial multiply-divide unit runs 64 multiply
// bits and then 128 quotient bits. From one accepted request to the next: a start runs six
// passes, a tick while running one to three passes and then a finish state, a start refused
// for zero period one pass, and load, abort, a tick while stopped or a start refused for zero
// velocity no pass. Reset is synchronous and active low; it clears the sequencer and profile
// state but not the datapath registers seg_r, k2_r, acc_r and out_data_r. A stalled result
// holds in the output register while the next request is taken. Configuration writes are
// taken only while idle and hold off the input for that cycle.
`timescale 1ns / 1ps
module trapezoid_motion_profile
  import tmp_pkg::*;
#(
  parameter int TICK_RATE_HZ = 1000,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] position_value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [47:0] commanded_position, [48] moving, rest zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TS = 32 - FRAC_BITS;

  ctl_state_t st_r, st_nxt;
  logic       issued_r;
  md_req_t    req;
  md_rsp_t    rsp;

  logic [31:0] dist_r;
  logic [23:0] vel_r;
  logic signed [47:0] cur_r, base_r;
  logic [31:0] k_r, p_r, third_r, two_r;
  logic        running_r, neg_r;
  logic [47:0] qm_r, lm_r, cm_r;
  logic [63:0] k2_r;
  logic signed [65:0] acc_r;
  logic [1:0]  seg_r;
  logic        out_valid_r;
  logic [48:0] out_data_r;

  logic        in_acc;
  op_t         op;
  logic [31:0] dabs;
  logic        out_load;
  logic signed [63:0] load_val;
  logic signed [65:0] pos, sum;
  logic signed [47:0] sat_sum;
  logic [55:0] pv;

  tmp_muldiv u_md (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign in_acc   = in_tvalid && in_tready;
  assign op       = op_t'(in_tuser);
  assign dabs     = dist_r[31] ? 32'(-dist_r) : dist_r;
  assign pv       = 56'(p_r) * 56'(vel_r);
  assign load_val = 64'(signed'(in_tdata)) <<< FRAC_BITS;
  assign pos      = neg_r ? -acc_r : acc_r;
  assign sum      = 66'(base_r) + pos;
  assign sat_sum  = (sum > POS_MAX) ? 48'(POS_MAX) : (sum < POS_MIN) ? 48'(POS_MIN) : 48'(sum);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op)
            OP_START: st_nxt = (vel_r == 24'd0) ? ST_OUT : ST_SP;
            OP_TICK: begin
              if (!running_r) st_nxt = ST_OUT;
              else if (k_r >= third_r && k_r < two_r) st_nxt = ST_TL;
              else st_nxt = ST_K2;
            end
            default: st_nxt = ST_OUT;
          endcase
        end
      end
      ST_SP:   if (rsp.done) st_nxt = (rsp.q == 64'd0) ? ST_OUT : ST_SQ;
      ST_SQ:   if (rsp.done) st_nxt = ST_SL;
      ST_SL:   if (rsp.done) st_nxt = ST_SC;
      ST_SC:   if (rsp.done) st_nxt = ST_S3;
      ST_S3:   if (rsp.done) st_nxt = ST_S23;
      ST_S23:  if (rsp.done) st_nxt = ST_OUT;
      ST_K2:   if (rsp.done) st_nxt = ST_TQ;
      ST_TQ:   if (rsp.done) st_nxt = (seg_r == 2'd0) ? ST_FIN : ST_TL;
      ST_TL:   if (rsp.done) st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_OUT;
      ST_OUT:  if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and divider requests.
  always_comb begin
    in_tready = (st_r == ST_IDLE) && !cfg_valid;
    out_load  = (st_r == ST_OUT) && (!out_valid_r || out_tready);
    req.start = 1'b0;
    req.a     = '0;
    req.b     = '0;
    req.d     = '0;
    req.cap   = CAP_ALL;
    case (st_r)
      ST_SP: begin
        req.a = 64'(dabs) * 64'd3;
        req.b = 64'(TICK_RATE_HZ);
        req.d = {39'd0, vel_r, 1'b0};
        req.cap = CAP_P;
      end
      ST_SQ: begin
        req.a = 64'(vel_r) * 64'd3;
        req.b = 64'd1 << 32;
        req.d = 64'(p_r) * 64'(2 * TICK_RATE_HZ);
        req.cap = CAP_COEF;
      end
      ST_SL: begin
        req.a = 64'(dabs) * 64'd3;
        req.b = 64'd1 << 32;
        req.d = {31'd0, p_r, 1'b0};
        req.cap = CAP_COEF;
      end
      ST_SC: begin
        req.a = 64'(dabs) * 64'(3 * TICK_RATE_HZ);
        req.b = 64'(dabs) << FRAC_BITS;
        req.d = {5'd0, pv, 3'd0};
        req.cap = CAP_COEF;
      end
      ST_S3: begin
        req.a = 64'(p_r);
        req.b = 64'd1;
        req.d = 64'd3;
      end
      ST_S23: begin
        req.a = 64'(p_r);
        req.b = 64'd2;
        req.d = 64'd3;
      end
      ST_K2: begin
        req.a = 64'(k_r);
        req.b = 64'(k_r);
        req.d = 64'd1;
      end
      ST_TQ: begin
        req.a = 64'(qm_r);
        req.b = k2_r;
        req.d = 64'd1 << TS;
        req.cap = CAP_TERM;
      end
      ST_TL: begin
        req.a = (seg_r == 2'd1) ? 64'(lm_r) : 64'(lm_r) * 64'd3;
        req.b = 64'(k_r);
        req.d = 64'd1 << TS;
        req.cap = CAP_TERM;
      end
      default: ;
    endcase
    case (st_r)
      ST_SP, ST_SQ, ST_SL, ST_SC, ST_S3, ST_S23, ST_K2, ST_TQ, ST_TL:
        req.start = !issued_r;
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      dist_r      <= '0;
      vel_r       <= '0;
      cur_r       <= '0;
      base_r      <= '0;
      k_r         <= '0;
      p_r         <= '0;
      third_r     <= '0;
      two_r       <= '0;
      running_r   <= 1'b0;
      neg_r       <= 1'b0;
      qm_r        <= '0;
      lm_r        <= '0;
      cm_r        <= '0;
    end else begin
      st_r <= st_nxt;
      if (req.start) issued_r <= 1'b1;
      else if (rsp.done) issued_r <= 1'b0;

      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_MOVE_DISTANCE:   dist_r <= cfg_data;
          REG_CRUISE_VELOCITY: vel_r  <= cfg_data[23:0];
          default: ;
        endcase
      end

      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_LOAD: begin
                cur_r <= (load_val > 64'(POS_MAX)) ? 48'(POS_MAX)
                       : (load_val < 64'(POS_MIN)) ? 48'(POS_MIN) : 48'(load_val);
              end
              OP_START: if (vel_r == 24'd0) running_r <= 1'b0;
              OP_ABORT: begin
                dist_r    <= '0;
                vel_r     <= '0;
                cur_r     <= '0;
                base_r    <= '0;
                k_r       <= '0;
                p_r       <= '0;
                third_r   <= '0;
                two_r     <= '0;
                running_r <= 1'b0;
                neg_r     <= 1'b0;
                qm_r      <= '0;
                lm_r      <= '0;
                cm_r      <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_SP: begin
          if (rsp.done) begin
            if (rsp.q == 64'd0) begin
              running_r <= 1'b0;
            end else begin
              p_r   <= rsp.q[31:0];
              neg_r <= dist_r[31];
            end
          end
        end
        ST_SQ:  if (rsp.done) qm_r <= rsp.q[47:0];
        ST_SL:  if (rsp.done) lm_r <= rsp.q[47:0];
        ST_SC:  if (rsp.done) cm_r <= rsp.q[47:0];
        ST_S3:  if (rsp.done) third_r <= rsp.q[31:0];
        ST_S23: begin
          if (rsp.done) begin
            two_r     <= rsp.q[31:0];
            k_r       <= '0;
            base_r    <= cur_r;
            running_r <= 1'b1;
          end
        end
        ST_FIN: begin
          cur_r <= sat_sum;
          if (k_r == p_r) running_r <= 1'b0;
          else k_r <= k_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && in_acc) begin
      if (k_r < third_r) seg_r <= 2'd0;
      else if (k_r < two_r) seg_r <= 2'd1;
      else seg_r <= 2'd2;
    end
    if (st_r == ST_K2 && rsp.done) k2_r <= rsp.q;
    if (st_r == ST_TQ && rsp.done) begin
      acc_r <= (seg_r == 2'd0) ? 66'(rsp.q) : -66'(rsp.q);
    end
    if (st_r == ST_TL && rsp.done) begin
      if (seg_r == 2'd1) acc_r <= 66'(rsp.q) - 66'(cm_r);
      else acc_r <= acc_r + 66'(rsp.q) - 66'(cm_r) * 66'sd5;
    end
    if (out_load) out_data_r <= {running_r, cur_r};
  end

  assign cfg_ready  = (st_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

endmodule

/* rtl/tmp_checker.sv */
// Port-level checker for the trapezoid motion profile generator, bound to the top level.
// Imports no package; depends only on the top level's ports.
`timescale 1ns / 1ps
module tmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Only one request is worked on at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Padding bits above the moving flag are zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:49] == 7'd0)
    else $error("nonzero padding in result");

endmodule

bind trapezoid_motion_profile tmp_checker u_tmp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

/* bench/trapezoid_motion_profile_test.sv */
// Self-checking bench for trapezoid_motion_profile: a directed table, then random move phases.
// Expected results come from a behavioral profile predictor or a typed row. Depends on tmp_pkg and the RTL.
`timescale 1ns / 1ps
module trapezoid_motion_profile_test;
  import tmp_pkg::*;

  localparam int RATE_HZ = 1000;
  localparam int FBITS   = 16;
  localparam longint POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint POS_LO = -64'sh0000_8000_0000_0000;
  localparam bit [63:0] TERM_LIMIT = 64'h1000_0000_0000_0000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] position_value
  logic [1:0]  in_tuser;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // [47:0] commanded_position, [48] moving, rest zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  trapezoid_motion_profile DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct packed {
    logic [47:0] position;
    logic        moving;
  } profile_point_t;

  typedef struct {
    bit        is_cfg;
    reg_idx_t  idx;
    bit [31:0] value;
    op_t       op;
    bit        typed;
    bit [47:0] exp_pos;
    bit        exp_moving;
  } stim_row_t;

  profile_point_t pending_points[$];
  int  error_count;
  bit  gaps_on;
  bit  stalls_on;
  bit  hold_req;

  // Predictor state.
  bit [31:0]   distance_reg;
  bit [23:0]   velocity_reg;
  longint      cur_pos, base_pos, quad_c, lin_c, offset_c;
  int unsigned tick_k, tick_total;
  bit          profile_running;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #80ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got, input logic [63:0] want);
    error_count++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  function automatic bit [63:0] scaled_quotient(input bit [63:0] a, input bit [63:0] b,
                                                input bit [63:0] d, input bit [63:0] cap);
    bit [127:0] prod;
    if (d == 0) return cap;
    prod = {64'b0, a} * {64'b0, b};
    prod = prod / {64'b0, d};
    if (prod > {64'b0, cap}) return cap;
    return prod[63:0];
  endfunction

  function automatic longint shaped_term(input longint c, input bit [63:0] m);
    bit [63:0]  mag;
    bit [127:0] prod;
    mag  = (c < 0) ? -c : c;
    prod = ({64'b0, mag} * {64'b0, m}) >> (32 - FBITS);
    if (prod > {64'b0, TERM_LIMIT}) prod = {64'b0, TERM_LIMIT};
    return (c < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function automatic longint clamp48(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  function automatic void clear_profile();
    distance_reg = 0; velocity_reg = 0;
    cur_pos = 0; base_pos = 0; quad_c = 0; lin_c = 0; offset_c = 0;
    tick_k = 0; tick_total = 0; profile_running = 0;
  endfunction

  function automatic void begin_move();
    longint    signed_dist;
    bit [63:0] d, v, r, p, q, l, c;
    signed_dist = longint'($signed(distance_reg));
    d = (signed_dist < 0) ? -signed_dist : signed_dist;
    v = velocity_reg;
    r = RATE_HZ;
    if (v == 0) begin
      profile_running = 0;
      return;
    end
    p = scaled_quotient(3 * d, r, 2 * v, CAP_P);
    if (p == 0) begin
      profile_running = 0;
      return;
    end
    q = scaled_quotient(3 * v, 64'd1 << 32, 2 * p * r, CAP_COEF);
    l = scaled_quotient(3 * d, 64'd1 << 32, 2 * p, CAP_COEF);
    c = scaled_quotient(3 * r * d, d << FBITS, 8 * p * v, CAP_COEF);
    quad_c   = (signed_dist < 0) ? -longint'(q) : longint'(q);
    lin_c    = (signed_dist < 0) ? -longint'(l) : longint'(l);
    offset_c = (signed_dist < 0) ? -longint'(c) : longint'(c);
    tick_total = p[31:0];
    tick_k = 0;
    base_pos = cur_pos;
    profile_running = 1;
  endfunction

  function automatic void advance_tick();
    bit [63:0] k, k2, third, two;
    longint    pos;
    if (!profile_running) return;
    k = tick_k;
    k2 = k * k;
    third = 64'(tick_total) / 3;
    two = (2 * 64'(tick_total)) / 3;
    if (k < third) pos = shaped_term(quad_c, k2);
    else if (k < two) pos = shaped_term(lin_c, k) - offset_c;
    else pos = -shaped_term(quad_c, k2) + shaped_term(3 * lin_c, k) - 5 * offset_c;
    cur_pos = clamp48(base_pos + pos);
    if (tick_k == tick_total) profile_running = 0;
    else tick_k++;
  endfunction

  function automatic profile_point_t predict_point(input op_t op, input bit [31:0] value);
    profile_point_t pt;
    case (op)
      OP_LOAD:  cur_pos = clamp48(longint'($signed(value)) * (64'sd1 <<< FBITS));
      OP_START: begin_move();
      OP_TICK:  advance_tick();
      default:  clear_profile();
    endcase
    pt.position = cur_pos[47:0];
    pt.moving   = profile_running;
    return pt;
  endfunction

  task automatic write_register(input reg_idx_t idx, input bit [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_MOVE_DISTANCE) distance_reg = value;
    else velocity_reg = value[23:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Leaves the clock at a falling edge so the caller may keep the request line high.
  task automatic send_request(input op_t op, input bit [31:0] value, input bit typed,
                              input bit [47:0] exp_pos, input bit exp_moving);
    profile_point_t pt;
    if (gaps_on) begin
      while ($urandom_range(99) < 10) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pt = predict_point(op, value);
    if (typed) begin
      pt.position = exp_pos;
      pt.moving   = exp_moving;
    end
    pending_points.push_back(pt);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 0);
      end else begin
        profile_point_t want;
        want = pending_points.pop_front();
        if (out_tdata[47:0] !== want.position)
          report_mismatch("commanded_position", out_tdata[47:0], want.position);
        if (out_tdata[48] !== want.moving) report_mismatch("moving", out_tdata[48], want.moving);
        if (out_tdata[55:49] !== 7'd0) report_mismatch("pad bits", out_tdata[55:49], 0);
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the output fills and the input backs up.
  initial begin
    int held;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        held = 0;
        out_tready <= 1'b0;
        while (held < 4000) begin
          @(negedge clk);
          held++;
        end
        hold_req = 0;
      end else begin
        out_tready <= !(stalls_on && $urandom_range(99) < 10);
      end
    end
  end

  stim_row_t rows[$];

  function automatic void add_cfg(input reg_idx_t idx, input bit [31:0] value);
    stim_row_t r;
    r = '{1, idx, value, OP_LOAD, 0, 0, 0};
    rows.push_back(r);
  endfunction

  function automatic void add_op(input op_t op, input bit [31:0] value, input bit typed,
                                 input bit [47:0] exp_pos, input bit exp_moving);
    stim_row_t r;
    r = '{0, REG_MOVE_DISTANCE, value, op, typed, exp_pos, exp_moving};
    rows.push_back(r);
  endfunction

  initial begin
    int  items;
    int  phase;
    int  target;
    int  roll;
    bit [31:0] move_dist;
    bit [23:0] vel;

    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; in_tuser = OP_LOAD;
    cfg_valid = 1'b0; cfg_index = REG_MOVE_DISTANCE; cfg_data = '0;
    error_count = 0; gaps_on = 0; stalls_on = 0; hold_req = 0;
    clear_profile();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: reset state, load extremes, refused starts, a short move and a long reverse move, abort.
    add_op(OP_TICK, 0, 1, 48'h0, 0);
    add_op(OP_LOAD, 32'h7FFF_FFFF, 1, 48'h7FFF_FFFF_0000, 0);
    add_op(OP_LOAD, 32'h8000_0000, 1, 48'h8000_0000_0000, 0);
    add_op(OP_START, 0, 1, 48'h8000_0000_0000, 0);
    add_cfg(REG_CRUISE_VELOCITY, 32'h00FF_FFFF);
    add_op(OP_START, 0, 1, 48'h8000_0000_0000, 0);
    add_op(OP_LOAD, 32'd100, 1, 48'h64_0000, 0);
    add_cfg(REG_MOVE_DISTANCE, 32'd50);
    add_cfg(REG_CRUISE_VELOCITY, 32'd10000);
    add_op(OP_START, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++) add_op(OP_TICK, 0, 0, 0, 0);
    add_op(OP_ABORT, 0, 1, 48'h0, 0);
    add_cfg(REG_MOVE_DISTANCE, 32'h8000_0001);
    add_cfg(REG_CRUISE_VELOCITY, 32'd1);
    add_op(OP_START, 0, 0, 0, 0);
    for (int i = 0; i < 3; i++) add_op(OP_TICK, 0, 0, 0, 0);
    add_op(OP_START, 0, 0, 0, 0);
    add_op(OP_ABORT, 0, 1, 48'h0, 0);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain_results();
        write_register(rows[i].idx, rows[i].value);
      end else begin
        send_request(rows[i].op, rows[i].value, rows[i].typed, rows[i].exp_pos,
                     rows[i].exp_moving);
      end
    end

    // Random phases: each sets a move period of at most 40 ticks or a full-range move, then mixed requests.
    items = 0;
    phase = 0;
    while (items < 2000) begin
      drain_results();
      gaps_on   = (phase < 3 || phase > 6);
      stalls_on = (phase < 3 || phase > 6);
      if (phase == 8) hold_req = 1;
      vel = (phase % 5 == 4) ? 24'hFF_FFFF : 24'($urandom_range(24'hFF_FFFF, 1));
      target = $urandom_range(40, 0);
      move_dist = 32'((64'(vel) * target) / 1500);
      if (phase % 7 == 6) move_dist = 32'h7FFF_FFFF;
      if ($urandom_range(1)) move_dist = -move_dist;
      write_register(REG_MOVE_DISTANCE, move_dist);
      write_register(REG_CRUISE_VELOCITY, {8'b0, vel});
      send_request(OP_START, $urandom, 0, 0, 0);
      for (int n = 0; n < 50; n++) begin
        roll = $urandom_range(99);
        if (roll < 75) send_request(OP_TICK, $urandom, 0, 0, 0);
        else if (roll < 85) send_request(OP_LOAD, $urandom, 0, 0, 0);
        else if (roll < 97) send_request(OP_START, $urandom, 0, 0, 0);
        else send_request(OP_ABORT, $urandom, 0, 0, 0);
      end
      items += 51;
      phase++;
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tmp_pkg.sv
rtl/tmp_muldiv.sv
rtl/trapezoid_motion_profile.sv
rtl/tmp_checker.sv
bench/trapezoid_motion_profile_test.sv
